### rtl/core/sample_direction_warp_top_assert.svh
// ---------------------------------------------------------------------------
// sample direction warp assertion macros
// shared concurrent assertion forms for the warp pipeline
// ---------------------------------------------------------------------------
`ifndef SAMPLE_DIRECTION_WARP_TOP_ASSERT_SVH
`define SAMPLE_DIRECTION_WARP_TOP_ASSERT_SVH

// same-cycle implication
`define SDW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sdw assertion failed");

// next-cycle implication
`define SDW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sdw assertion failed");

`endif

### rtl/core/sdw_pkg.sv
// ---------------------------------------------------------------------------
// sdw_pkg
// types, constants and step functions of the sample direction warp
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdw_pkg;

  localparam int DefCordicStages = 16;
  localparam int SqrtSteps       = 17;
  localparam int SqrtStart       = 4;

  localparam logic signed [23:0] One       = 24'sd65536;
  localparam logic signed [19:0] GainQ16   = 20'sd39797;
  localparam logic [19:0]        TwoPiQ16  = 20'd411775;

  typedef enum logic [2:0] {
    KIND_SPHERE   = 3'd0,
    KIND_HEMI     = 3'd1,
    KIND_COS_HEMI = 3'd2,
    KIND_CONE     = 3'd3,
    KIND_DISK     = 3'd4,
    KIND_TRI      = 3'd5
  } kind_e;

  typedef struct packed {
    logic [33:0] rad;
    logic [18:0] rem;
    logic [16:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
  } cordic_t;

  typedef struct packed {
    kind_e              kind;
    logic [15:0]        u;
    logic [15:0]        v;
    logic signed [39:0] prod;
    logic signed [19:0] ct;
    cordic_t            cr;
    sqrt_t              sa;
    sqrt_t              sb;
    logic signed [37:0] mx;
    logic signed [37:0] my;
    logic signed [19:0] ox;
    logic signed [19:0] oy;
    logic signed [19:0] oz;
  } stage_t;

  function automatic logic signed [19:0] atan_q16(input int i);
    logic signed [19:0] a;
    unique case (i)
      0:       a = 20'sd51472;
      1:       a = 20'sd30386;
      2:       a = 20'sd16055;
      3:       a = 20'sd8150;
      4:       a = 20'sd4091;
      5:       a = 20'sd2047;
      6:       a = 20'sd1024;
      7:       a = 20'sd512;
      8:       a = 20'sd256;
      9:       a = 20'sd128;
      10:      a = 20'sd64;
      11:      a = 20'sd32;
      12:      a = 20'sd16;
      13:      a = 20'sd8;
      14:      a = 20'sd4;
      15:      a = 20'sd2;
      16:      a = 20'sd1;
      17:      a = 20'sd1;
      default: a = 20'sd0;
    endcase
    return a;
  endfunction

  function automatic cordic_t cordic_step(input cordic_t c, input int i);
    cordic_t n;
    if (c.z >= 0) begin
      n.x = c.x - (c.y >>> i);
      n.y = c.y + (c.x >>> i);
      n.z = c.z - atan_q16(i);
    end else begin
      n.x = c.x + (c.y >>> i);
      n.y = c.y - (c.x >>> i);
      n.z = c.z + atan_q16(i);
    end
    return n;
  endfunction

  function automatic sqrt_t sqrt_init(input logic [16:0] arg);
    sqrt_t s;
    s.rad  = {1'b0, arg, 16'd0};
    s.rem  = '0;
    s.root = '0;
    return s;
  endfunction

  function automatic sqrt_t sqrt_step(input sqrt_t s);
    sqrt_t       n;
    logic [20:0] rem4;
    logic [20:0] test;
    rem4  = {s.rem, s.rad[33:32]};
    test  = {2'b00, s.root, 2'b01};
    n.rad = {s.rad[31:0], 2'b00};
    if (rem4 >= test) begin
      n.rem  = 19'(rem4 - test);
      n.root = {s.root[15:0], 1'b1};
    end else begin
      n.rem  = rem4[18:0];
      n.root = {s.root[15:0], 1'b0};
    end
    return n;
  endfunction

  // round half up by 16 fraction bits
  function automatic logic signed [23:0] rnd16(input logic signed [39:0] p);
    logic signed [39:0] t;
    t = p + 40'sd32768;
    return t[39:16];
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [23:0] a);
    logic signed [19:0] r;
    if (a > 24'sd524287) begin
      r = 20'sd524287;
    end else if (a < -24'sd524288) begin
      r = -20'sd524288;
    end else begin
      r = a[19:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/sample_direction_warp_top.sv
// ---------------------------------------------------------------------------
// sample_direction_warp_top
// warps a uniform 2d sample into a sphere, hemisphere, cosine hemisphere or
// cone direction, a polar disk sample or a triangle barycentric pair
// ---------------------------------------------------------------------------
// Takes one item per clock cycle while no result is parked in the skid and
// returns one result per item, in order. The azimuth CORDIC runs one
// rotation per stage alongside a square root pipeline that resolves one root
// bit per stage (17 stages), after a front end of four stages (cone scale,
// cos theta, its square, root argument) and before one multiply stage and one
// rounding stage.
// A two-entry output (result register plus skid) stops the whole pipeline
// only while a result is parked in the skid. The cone register is written on
// cfg_valid_i and is meant to change only while the block is idle.
`timescale 1ns / 1ps

`include "sample_direction_warp_top_assert.svh"

module sample_direction_warp_top #(
  parameter int CORDIC_STAGES = sdw_pkg::DefCordicStages
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [17:0] cfg_data_i,       // cone_cos_max
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // sample_u, sample_v
  input  logic [2:0]  s_axis_tuser_i,   // req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o    // comp_x, comp_y, comp_z, zero pad
);
  import sdw_pkg::*;

  localparam int SqrtLast = SqrtStart + SqrtSteps - 1;
  localparam int MidLast  = (CORDIC_STAGES > SqrtLast) ? CORDIC_STAGES : SqrtLast;
  localparam int NumStg   = MidLast + 3;

  logic signed [17:0] cone_q;
  logic [NumStg-1:0]  vld_q;
  stage_t             stg_q [NumStg];
  stage_t             in_d;
  logic               en;
  logic               skid_vld_q;
  logic [59:0]        skid_q;
  logic [59:0]        last_data;

  assign cfg_ready_o     = 1'b1;
  assign en              = !skid_vld_q;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cone_q <= '0;
    end else if (cfg_valid_i) begin
      cone_q <= cfg_data_i;
    end
  end

  always_comb begin : in_stage
    logic signed [18:0] omr;
    logic [32:0]        zp;
    omr          = 19'sd65536 - {cone_q[17], cone_q};
    zp           = 33'(s_axis_tdata_i[29:16]) * 33'(TwoPiQ16) + 33'd32768;
    in_d         = '0;
    in_d.kind    = kind_e'(s_axis_tuser_i);
    in_d.u       = s_axis_tdata_i[15:0];
    in_d.v       = s_axis_tdata_i[31:16];
    in_d.prod    = 40'($signed({1'b0, s_axis_tdata_i[15:0]}) * omr);
    in_d.cr.x    = GainQ16;
    in_d.cr.y    = '0;
    in_d.cr.z    = $signed({3'b000, zp[32:16]});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      stg_q[0] <= in_d;
    end
  end

  for (genvar j = 1; j < NumStg; j++) begin : g_stage
    stage_t nxt;

    always_comb begin : stage_logic
      stage_t             s;
      logic signed [23:0] t;
      logic signed [19:0] cp;
      logic signed [19:0] sp;
      logic signed [19:0] ma;
      logic signed [19:0] mb;
      logic signed [19:0] rx;
      s  = stg_q[j-1];
      t  = '0;
      cp = '0;
      sp = '0;
      ma = '0;
      mb = '0;
      rx = '0;
      if (j <= CORDIC_STAGES) begin
        s.cr = cordic_step(stg_q[j-1].cr, j - 1);
      end
      if (j == 1) begin
        unique case (s.kind)
          KIND_SPHERE: s.ct = 20'(One - 24'(s.u) - 24'(s.u));
          KIND_HEMI:   s.ct = $signed({4'b0000, s.u});
          KIND_CONE:   s.ct = 20'(One - rnd16(s.prod));
          default:     s.ct = '0;
        endcase
      end else if (j == 2) begin
        s.prod = 40'(s.ct * s.ct);
      end else if (j == 3) begin
        if (s.kind == KIND_COS_HEMI) begin
          t = One - 24'(s.u);
        end else begin
          t = One - rnd16(s.prod);
        end
        s.sa = sqrt_init((t <= 0) ? 17'd0 : t[16:0]);
        s.sb = sqrt_init({1'b0, s.u});
      end else if (j >= SqrtStart && j <= SqrtLast) begin
        s.sa = sqrt_step(s.sa);
        s.sb = sqrt_step(s.sb);
      end else if (j == NumStg - 2) begin
        unique case (s.v[15:14])
          2'd0: begin cp = s.cr.x;  sp = s.cr.y;  end
          2'd1: begin cp = -s.cr.y; sp = s.cr.x;  end
          2'd2: begin cp = -s.cr.x; sp = -s.cr.y; end
          default: begin cp = s.cr.y; sp = -s.cr.x; end
        endcase
        if (s.kind == KIND_DISK) begin
          ma = $signed({4'b0000, s.v});
          mb = $signed(TwoPiQ16);
        end else if (s.kind == KIND_TRI) begin
          ma = $signed({3'b000, s.sb.root});
          mb = $signed({4'b0000, s.v});
        end else begin
          ma = $signed({3'b000, s.sa.root});
          mb = sp;
        end
        s.mx = 38'($signed({3'b000, s.sa.root}) * cp);
        s.my = 38'(ma * mb);
      end else if (j == NumStg - 1) begin
        rx = (s.kind == KIND_COS_HEMI) ? $signed({3'b000, s.sb.root}) : s.ct;
        unique case (s.kind)
          KIND_SPHERE, KIND_HEMI, KIND_COS_HEMI, KIND_CONE: begin
            s.ox = sat20(rnd16(40'(s.mx)));
            s.oy = sat20(rnd16(40'(s.my)));
            s.oz = rx;
          end
          KIND_DISK: begin
            s.ox = $signed({3'b000, s.sb.root});
            s.oy = sat20(rnd16(40'(s.my)));
            s.oz = '0;
          end
          KIND_TRI: begin
            s.ox = 20'(One - 24'(s.sb.root));
            s.oy = sat20(rnd16(40'(s.my)));
            s.oz = '0;
          end
          default: begin
            s.ox = '0;
            s.oy = '0;
            s.oz = '0;
          end
        endcase
      end
      nxt = s;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        stg_q[j] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStg-2:0], s_axis_tvalid_i};
    end
  end

  assign last_data = {stg_q[NumStg-1].oz, stg_q[NumStg-1].oy, stg_q[NumStg-1].ox};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      skid_vld_q <= !m_axis_tready_i;
    end else begin
      skid_vld_q <= vld_q[NumStg-1] && !m_axis_tready_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_vld_q) begin
      skid_q <= last_data;
    end
  end

  assign m_axis_tvalid_o = skid_vld_q || vld_q[NumStg-1];
  assign m_axis_tdata_o  = {4'b0000, (skid_vld_q ? skid_q : last_data)};

  `SDW_ASSERT_IMP(a_skid_blocks_input, clk_i, rst_ni, skid_vld_q, !s_axis_tready_o)
  `SDW_ASSERT_NXT(a_stall_freezes_pipe, clk_i, rst_ni, skid_vld_q && !m_axis_tready_i, $stable(vld_q))
  `SDW_ASSERT_IMP(a_skid_from_result, clk_i, rst_ni, $rose(skid_vld_q), $past(vld_q[NumStg-1]))
  `SDW_ASSERT_IMP(a_unused_kind_zero, clk_i, rst_ni, vld_q[NumStg-1] && (stg_q[NumStg-1].kind == 3'd6 || stg_q[NumStg-1].kind == 3'd7), last_data == '0)

endmodule
